@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/sce_pkg.sv @@
package sce_pkg;

    localparam int unsigned NET_W  = 12;
    localparam int unsigned COST_W = 32;

    localparam logic [COST_W-1:0] COST_INF = 32'h8000_0000;

    // command codes
    localparam logic CMD_SET_PI = 1'b0;
    localparam logic CMD_FANIN  = 1'b1;

    // gate kinds
    localparam logic [3:0] KIND_FANOUT = 4'd0;
    localparam logic [3:0] KIND_BUF    = 4'd1;
    localparam logic [3:0] KIND_INV    = 4'd2;
    localparam logic [3:0] KIND_AND    = 4'd3;
    localparam logic [3:0] KIND_NAND   = 4'd4;
    localparam logic [3:0] KIND_OR     = 4'd5;
    localparam logic [3:0] KIND_NOR    = 4'd6;
    localparam logic [3:0] KIND_XOR    = 4'd7;
    localparam logic [3:0] KIND_XNOR   = 4'd8;

    typedef struct packed {
        logic             command;
        logic [3:0]       gate_kind;
        logic [NET_W-1:0] out_net;
        logic [NET_W-1:0] fanin_net;
        logic             last_fanin;
    } t_item;

    typedef struct packed {
        logic [NET_W-1:0]  result_net;
        logic [COST_W-1:0] zero_cost;
        logic [COST_W-1:0] one_cost;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic red_step;
        logic mem_rd;
        logic acc;
        logic calc1;
        logic calc2;
        logic calc3;
        logic wr_gate;
        logic wr_pi;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic red_done;
        logic is_pi;
        logic is_last;
        logic kind_ok;
    } t_dp_status;

    function automatic logic [COST_W-1:0] umin(input logic [COST_W-1:0] x,
                                               input logic [COST_W-1:0] y);
        return (x > y) ? y : x;
    endfunction

endpackage

@@ src/sce_dp.sv @@
`include "assert_macros.svh"

module sce_dp #(
    parameter int unsigned NET_COUNT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sce_pkg::t_item      i_item,
    input  sce_pkg::t_dp_cmd    i_cmd,
    output sce_pkg::t_dp_status o_status,
    output logic                o_result_valid,
    output sce_pkg::t_result    o_result
);

    localparam int unsigned IW        = (NET_COUNT > 1) ? $clog2(NET_COUNT) : 1;
    localparam int unsigned NW        = sce_pkg::NET_W;
    localparam int unsigned CW        = sce_pkg::COST_W;
    localparam bit          IS_POW2   = ((NET_COUNT & (NET_COUNT - 1)) == 0);
    localparam int unsigned RED_STEPS =
        (IS_POW2 || NET_COUNT >= (1 << NW)) ? 0 : (NW + 1 - IW);
    localparam int unsigned RCW       = $clog2(RED_STEPS + 1) > 0 ? $clog2(RED_STEPS + 1) : 1;
    localparam int unsigned DW        = 24;
    localparam int unsigned DSH       = (RED_STEPS > 0) ? (RED_STEPS - 1) : 0;
    localparam logic [DW-1:0] DIV_INIT = DW'(NET_COUNT) << DSH;

    // captured item and index reduction
    logic [3:0]     r_kind;
    logic           r_cmd_fanin;
    logic           r_last;
    logic [NW-1:0]  r_onet_v;
    logic [NW-1:0]  r_fnet_v;
    logic [DW-1:0]  r_div;
    logic [RCW-1:0] r_red_cnt;

    // cost store read
    logic [2*CW-1:0] r_rd;

    // accumulation state
    logic [CW-1:0]   r_min0, r_min1, r_sum0, r_sum1;
    logic            r_zero_inf, r_one_inf;
    logic [2*CW-1:0] r_first, r_second;
    logic [1:0]      r_cnt;

    // evaluation pipeline
    logic [CW-1:0] r_u0, r_u1, r_u2, r_u3, r_u4, r_u5;
    logic [CW-1:0] r_m0, r_m1, r_k;
    logic [CW-1:0] r_c0, r_c1;

    // result register
    logic             r_valid;
    sce_pkg::t_result r_res;

    logic [2*CW-1:0] mem [NET_COUNT];

    logic [IW-1:0] w_oidx, w_fidx;
    logic [NW-1:0] w_onet_out;

    // map reduced net numbers onto memory addresses
    if (IW <= NW) begin : g_idx_narrow
        assign w_oidx = r_onet_v[IW-1:0];
        assign w_fidx = r_fnet_v[IW-1:0];
        if (IW < NW) begin : g_out_pad
            assign w_onet_out = {{(NW-IW){1'b0}}, w_oidx};
        end else begin : g_out_full
            assign w_onet_out = r_onet_v;
        end
    end else begin : g_idx_wide
        assign w_oidx     = {{(IW-NW){1'b0}}, r_onet_v};
        assign w_fidx     = {{(IW-NW){1'b0}}, r_fnet_v};
        assign w_onet_out = r_onet_v;
    end

    // capture item and reduce both net numbers one step at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_cnt <= '0;
        end else if (i_cmd.load) begin
            r_red_cnt <= RCW'(RED_STEPS);
        end else if (i_cmd.red_step) begin
            r_red_cnt <= r_red_cnt - RCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_item.gate_kind;
            r_cmd_fanin <= (i_item.command == sce_pkg::CMD_FANIN);
            r_last      <= i_item.last_fanin;
            r_onet_v    <= i_item.out_net;
            r_fnet_v    <= i_item.fanin_net;
            r_div       <= DIV_INIT;
        end else if (i_cmd.red_step) begin
            if (DW'(r_onet_v) >= r_div) begin
                r_onet_v <= NW'(DW'(r_onet_v) - r_div);
            end
            if (DW'(r_fnet_v) >= r_div) begin
                r_fnet_v <= NW'(DW'(r_fnet_v) - r_div);
            end
            r_div <= r_div >> 1;
        end
    end

    // cost store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pi) begin
            mem[w_oidx] <= {CW'(1), CW'(1)};
        end else if (i_cmd.wr_gate) begin
            mem[w_oidx] <= {r_c1, r_c0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd <= mem[w_fidx];
        end
    end

    // running minima, sticky sums and kept fanins
    logic [CW-1:0]   f0, f1, b_s0, b_s1;
    logic            fresh, b_i0, b_i1;
    logic [CW-1:0]   n_min0, n_min1, n_sum0, n_sum1;
    logic            n_zero_inf, n_one_inf;
    logic [2*CW-1:0] n_first, n_second;
    logic [1:0]      n_cnt;

    always_comb begin
        f0         = r_rd[CW-1:0];
        f1         = r_rd[2*CW-1:CW];
        fresh      = (r_cnt == 2'd0);
        n_min0     = fresh ? f0 : sce_pkg::umin(r_min0, f0);
        n_min1     = fresh ? f1 : sce_pkg::umin(r_min1, f1);
        b_s0       = fresh ? '0 : r_sum0;
        b_s1       = fresh ? '0 : r_sum1;
        b_i0       = fresh ? 1'b0 : r_zero_inf;
        b_i1       = fresh ? 1'b0 : r_one_inf;
        n_sum0     = b_i0 ? b_s0 : ((f0 == sce_pkg::COST_INF) ? sce_pkg::COST_INF : b_s0 + f0);
        n_sum1     = b_i1 ? b_s1 : ((f1 == sce_pkg::COST_INF) ? sce_pkg::COST_INF : b_s1 + f1);
        n_zero_inf = b_i0 | (f0 == sce_pkg::COST_INF);
        n_one_inf  = b_i1 | (f1 == sce_pkg::COST_INF);
        n_first    = fresh ? r_rd : r_first;
        n_second   = fresh ? '0 : ((r_cnt == 2'd1) ? r_rd : r_second);
        n_cnt      = r_last ? 2'd0 : ((r_cnt == 2'd2) ? 2'd2 : r_cnt + 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min0     <= '0;
            r_min1     <= '0;
            r_sum0     <= '0;
            r_sum1     <= '0;
            r_zero_inf <= 1'b0;
            r_one_inf  <= 1'b0;
            r_first    <= '0;
            r_second   <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.acc) begin
            r_min0     <= n_min0;
            r_min1     <= n_min1;
            r_sum0     <= n_sum0;
            r_sum1     <= n_sum1;
            r_zero_inf <= n_zero_inf;
            r_one_inf  <= n_one_inf;
            r_first    <= n_first;
            r_second   <= n_second;
            r_cnt      <= n_cnt;
        end
    end

    // gate evaluation in three stages, with xor and xnor expansion
    logic [CW-1:0] a0, a1, b0, b1;

    always_comb begin
        a0 = r_first[CW-1:0];
        a1 = r_first[2*CW-1:CW];
        b0 = r_second[CW-1:0];
        b1 = r_second[2*CW-1:CW];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            if (r_kind == sce_pkg::KIND_XNOR) begin
                r_u0 <= a0 + CW'(1);
                r_u1 <= b0 + CW'(1);
                r_u2 <= a1 + b1 + CW'(1);
                r_u3 <= a1 + CW'(2);
                r_u4 <= b1 + CW'(2);
                r_u5 <= a0 + b0 + CW'(3);
            end else begin
                r_u0 <= a0 + CW'(1);
                r_u1 <= b1 + CW'(2);
                r_u2 <= a1 + b0 + CW'(2);
                r_u3 <= a1 + CW'(1);
                r_u4 <= b0 + CW'(2);
                r_u5 <= a0 + b1 + CW'(2);
            end
        end
        if (i_cmd.calc2) begin
            r_m0 <= sce_pkg::umin(r_u0, r_u1);
            r_m1 <= sce_pkg::umin(r_u3, r_u4);
            r_k  <= sce_pkg::umin(r_u2, r_u5);
        end
        if (i_cmd.calc3) begin
            unique case (r_kind)
                sce_pkg::KIND_FANOUT: begin
                    r_c0 <= a0;
                    r_c1 <= a1;
                end
                sce_pkg::KIND_BUF: begin
                    r_c0 <= a0 + CW'(1);
                    r_c1 <= a1 + CW'(1);
                end
                sce_pkg::KIND_INV: begin
                    r_c0 <= a1 + CW'(1);
                    r_c1 <= a0 + CW'(1);
                end
                sce_pkg::KIND_AND: begin
                    r_c0 <= r_min0 + CW'(1);
                    r_c1 <= r_sum1 + CW'(1);
                end
                sce_pkg::KIND_NAND: begin
                    r_c0 <= r_sum1 + CW'(1);
                    r_c1 <= r_min0 + CW'(1);
                end
                sce_pkg::KIND_OR: begin
                    r_c0 <= r_sum0 + CW'(1);
                    r_c1 <= r_min1 + CW'(1);
                end
                sce_pkg::KIND_NOR: begin
                    r_c0 <= r_min1 + CW'(1);
                    r_c1 <= r_sum0 + CW'(1);
                end
                sce_pkg::KIND_XOR, sce_pkg::KIND_XNOR: begin
                    r_c0 <= r_m0 + r_m1 + CW'(1);
                    r_c1 <= r_k + CW'(1);
                end
                default: begin
                    r_c0 <= r_c0;
                    r_c1 <= r_c1;
                end
            endcase
        end
    end

    // result strobe and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.wr_pi | i_cmd.wr_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pi) begin
            r_res.result_net <= w_onet_out;
            r_res.zero_cost  <= CW'(1);
            r_res.one_cost   <= CW'(1);
        end else if (i_cmd.wr_gate) begin
            r_res.result_net <= w_onet_out;
            r_res.zero_cost  <= r_c0;
            r_res.one_cost   <= r_c1;
        end
    end

    assign o_status.red_done = (r_red_cnt == '0);
    assign o_status.is_pi    = !r_cmd_fanin;
    assign o_status.is_last  = r_last;
    assign o_status.kind_ok  = (r_kind <= sce_pkg::KIND_XNOR);
    assign o_result_valid    = r_valid;
    assign o_result          = r_res;

    `ASSERT_HOLDS(a_zero_inf_sticky, i_clk, i_rst_n, !r_zero_inf || (r_sum0 == sce_pkg::COST_INF))
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_valid, !r_valid)
    `ASSERT_IMPL(a_fanin_reduced, i_clk, i_rst_n, i_cmd.mem_rd, (RED_STEPS == 0) || (DW'(r_fnet_v) < DW'(NET_COUNT)))

endmodule

@@ src/sce_ctrl.sv @@
`include "assert_macros.svh"

module sce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sce_pkg::t_dp_status i_status,
    output sce_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_ACC,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_WR_GATE,
        S_WR_PI
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start && !r_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (!i_status.red_done) begin
                    o_cmd.red_step = 1'b1;
                end else if (i_status.is_pi) begin
                    n_state = S_WR_PI;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.is_last && i_status.kind_ok) begin
                    n_state = S_CALC1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_CALC3;
            end
            S_CALC3: begin
                o_cmd.calc3 = 1'b1;
                n_state     = S_WR_GATE;
            end
            S_WR_GATE: begin
                o_cmd.wr_gate = 1'b1;
                n_state       = S_IDLE;
            end
            S_WR_PI: begin
                o_cmd.wr_pi = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

    `ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !r_busy, r_busy)
    `ASSERT_IMPL(a_busy_matches_state, i_clk, i_rst_n, r_busy, r_state != S_IDLE)
    `ASSERT_IMPL(a_write_after_calc, i_clk, i_rst_n, r_state == S_WR_GATE, $past(r_state) == S_CALC3)

endmodule

@@ src/scoap_controllability_engine.sv @@
// set_pi item: net number reduction, then unit costs written and result strobed
// fanin item: reduction, one cost-store read and accumulation; no result unless last
// last fanin of a known gate kind: then evaluated, written and its result strobed
// net number reduction is skipped when NET_COUNT is a power of two or above 4095
// synchronous active-low reset idles the controller and clears the accumulators
// cost store is not cleared; results are strobed for one cycle, no back-pressure
module scoap_controllability_engine #(
    parameter int unsigned NET_COUNT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sce_pkg::t_item   i_item,
    output logic             o_result_valid,
    output sce_pkg::t_result o_result
);

    sce_pkg::t_dp_cmd    w_cmd;
    sce_pkg::t_dp_status w_status;

    // sequencing of one item
    sce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // cost store, accumulators and gate evaluation
    sce_dp #(
        .NET_COUNT (NET_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
